>>> hdl/tree_lca_distance_top_assert.svh
// assertion macros shared by the checker of the tree lca block
`ifndef TREE_LCA_DISTANCE_TOP_ASSERT_SVH
`define TREE_LCA_DISTANCE_TOP_ASSERT_SVH

// property that holds in the same cycle as its trigger
`define LCAD_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// property that holds in the cycle after its trigger
`define LCAD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/lcad_pkg.sv
// types, constants and helpers shared by the tree lca block
`default_nettype none
package lcad_pkg;

  // table geometry; the node count is a power of two
  localparam int MAX_NODES  = 1024;
  localparam int LOG_LEVELS = 10;

  localparam int FIELD_W   = 10;
  localparam int DIST_W    = 11;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int LVL_W     = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
  localparam int ANC_AW    = LVL_W + NODE_W;
  localparam int ANC_DEPTH = LOG_LEVELS * MAX_NODES;
  localparam int STEP_W    = ((FIELD_W > LOG_LEVELS) ? FIELD_W : LOG_LEVELS) + 1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN
  } build_state_e;

  typedef enum logic [3:0] {
    Q_IDLE,
    Q_RD,
    Q_SWAP,
    Q_EVAL,
    Q_ANC,
    Q_CHECK,
    Q_CMP,
    Q_FIN,
    Q_DIST
  } query_state_e;

  // access bundle for the ancestor memory
  typedef struct packed {
    logic [ANC_AW-1:0]  addr_a;
    logic [ANC_AW-1:0]  addr_b;
    logic               we;
    logic [ANC_AW-1:0]  waddr;
    logic [FIELD_W-1:0] wdata;
  } anc_req_t;

  // read addresses for the depth memory
  typedef struct packed {
    logic [NODE_W-1:0] addr_a;
    logic [NODE_W-1:0] addr_b;
  } dep_req_t;

  // ancestor memory address: level in the upper bits, node below
  function automatic logic [ANC_AW-1:0] anc_addr(input logic [LVL_W-1:0] lv,
                                                 input logic [NODE_W-1:0] node);
    return {lv, node};
  endfunction

endpackage
`default_nettype wire

>>> hdl/lcad_ram.sv
// generic ram: one write port, two registered read ports
`default_nettype none
module lcad_ram #(
  parameter int WIDTH  = 10,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]  rdata_a_o,
  output logic      [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

>>> hdl/lcad_build.sv
// ancestor table builder: one node per cycle in a level, via a three-step pipe
`default_nettype none
module lcad_build (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [lcad_pkg::NODE_W-1:0]   last_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  rdata_a_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  rdata_b_i,
  output lcad_pkg::anc_req_t                 req_o,
  output logic                               busy_o
);
  import lcad_pkg::*;

  build_state_e      state_q, state_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [NODE_W-1:0] idx_q, idx_d;
  logic [NODE_W-1:0] last_q, last_d;
  logic              v1_q, v1_d, v2_q, v2_d;
  logic [NODE_W-1:0] n1_q, n1_d, n2_q, n2_d;
  logic [LVL_W-1:0]  lvl_prev;

  assign lvl_prev = lvl_q - LVL_W'(1);
  assign busy_o   = (state_q != B_IDLE);

  // next state, level and index counters, pipe stages
  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    idx_d   = idx_q;
    last_d  = last_q;
    v1_d    = 1'b0;
    n1_d    = idx_q;
    v2_d    = v1_q;
    n2_d    = n1_q;
    case (state_q)
      B_IDLE: begin
        if (go_i && (LOG_LEVELS > 1)) begin
          state_d = B_RUN;
          lvl_d   = LVL_W'(1);
          idx_d   = '0;
          last_d  = last_i;
        end
      end
      B_RUN: begin
        v1_d = 1'b1;
        if (idx_q == last_q) begin
          state_d = B_DRAIN;
        end else begin
          idx_d = idx_q + NODE_W'(1);
        end
      end
      B_DRAIN: begin
        if (!v1_q && !v2_q) begin
          if (lvl_q == LVL_W'(LOG_LEVELS - 1)) begin
            state_d = B_IDLE;
          end else begin
            state_d = B_RUN;
            lvl_d   = lvl_q + LVL_W'(1);
            idx_d   = '0;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // memory accesses: read parent, read its ancestor, write the new level
  always_comb begin
    req_o.addr_a = anc_addr(lvl_prev, idx_q);
    req_o.addr_b = anc_addr(lvl_prev, NODE_W'(rdata_a_i));
    req_o.we     = v2_q;
    req_o.waddr  = anc_addr(lvl_q, n2_q);
    req_o.wdata  = FIELD_W'(NODE_W'(rdata_b_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      lvl_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      lvl_q   <= lvl_d;
      idx_q   <= idx_d;
    end
  end

  // payload of the pipe
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    n1_q   <= n1_d;
    n2_q   <= n2_d;
  end

endmodule
`default_nettype wire

>>> hdl/lcad_query.sv
// query sequencer: equalize depths, lift both nodes, then measure the path
`default_nettype none
module lcad_query (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [lcad_pkg::NODE_W-1:0]   node_i,
  input  wire logic [lcad_pkg::NODE_W-1:0]   other_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  anc_a_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  anc_b_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  dep_a_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  dep_b_i,
  output lcad_pkg::anc_req_t                 anc_req_o,
  output lcad_pkg::dep_req_t                 dep_req_o,
  output logic                               busy_o,
  output logic                               res_valid_o,
  output logic [lcad_pkg::FIELD_W-1:0]       res_ancestor_o,
  output logic [lcad_pkg::DIST_W-1:0]        res_dist_o
);
  import lcad_pkg::*;

  query_state_e       state_q, state_d;
  logic [NODE_W-1:0]  a_q, a_d, b_q, b_d;
  logic [NODE_W-1:0]  low_q, low_d, high_q, high_d, c_q, c_d;
  logic [FIELD_W-1:0] da_q, da_d, db_q, db_d;
  logic [FIELD_W-1:0] dlow_q, dlow_d, dhigh_q, dhigh_d;
  logic               fresh_q, fresh_d;
  logic [LVL_W-1:0]   lv_q, lv_d;
  logic               vld_q, vld_d;
  logic [FIELD_W-1:0] anc_q, anc_d;
  logic [DIST_W-1:0]  dist_q, dist_d;

  logic [FIELD_W-1:0] dl;
  logic               lift;
  logic [NODE_W-1:0]  pl, ph, nlow, nhigh, anc_node;
  logic [LVL_W-1:0]   lv_next;

  // depth of the lower node comes straight from memory after a lift
  assign dl       = fresh_q ? dep_a_i : dlow_q;
  assign lift     = STEP_W'(dl) >= (STEP_W'(dhigh_q) + (STEP_W'(1) << lv_q));
  assign pl       = NODE_W'(anc_a_i);
  assign ph       = NODE_W'(anc_b_i);
  assign nlow     = (pl != ph) ? pl : low_q;
  assign nhigh    = (pl != ph) ? ph : high_q;
  assign anc_node = NODE_W'(anc_a_i);
  assign lv_next  = lv_q - LVL_W'(1);

  assign busy_o         = (state_q != Q_IDLE);
  assign res_valid_o    = vld_q;
  assign res_ancestor_o = anc_q;
  assign res_dist_o     = dist_q;

  // next state and datapath registers
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    low_d   = low_q;
    high_d  = high_q;
    c_d     = c_q;
    da_d    = da_q;
    db_d    = db_q;
    dlow_d  = dlow_q;
    dhigh_d = dhigh_q;
    fresh_d = 1'b0;
    lv_d    = lv_q;
    vld_d   = 1'b0;
    anc_d   = anc_q;
    dist_d  = dist_q;
    case (state_q)
      Q_IDLE: begin
        if (go_i) begin
          state_d = Q_RD;
          a_d     = node_i;
          b_d     = other_i;
        end
      end
      Q_RD: state_d = Q_SWAP;
      Q_SWAP: begin
        da_d = dep_a_i;
        db_d = dep_b_i;
        if (dep_a_i < dep_b_i) begin
          low_d   = b_q;
          high_d  = a_q;
          dlow_d  = dep_b_i;
          dhigh_d = dep_a_i;
        end else begin
          low_d   = a_q;
          high_d  = b_q;
          dlow_d  = dep_a_i;
          dhigh_d = dep_b_i;
        end
        lv_d    = LVL_W'(LOG_LEVELS - 1);
        state_d = Q_EVAL;
      end
      Q_EVAL: begin
        dlow_d = dl;
        if (lift) begin
          state_d = Q_ANC;
        end else if (lv_q == '0) begin
          state_d = Q_CHECK;
        end else begin
          lv_d = lv_next;
        end
      end
      Q_ANC: begin
        low_d   = anc_node;
        fresh_d = 1'b1;
        if (lv_q == '0) begin
          state_d = Q_CHECK;
        end else begin
          lv_d    = lv_next;
          state_d = Q_EVAL;
        end
      end
      Q_CHECK: begin
        if (low_q == high_q) begin
          c_d     = low_q;
          state_d = Q_DIST;
        end else begin
          lv_d    = LVL_W'(LOG_LEVELS - 1);
          state_d = Q_CMP;
        end
      end
      Q_CMP: begin
        low_d  = nlow;
        high_d = nhigh;
        if (lv_q == '0) begin
          state_d = Q_FIN;
        end else begin
          lv_d = lv_next;
        end
      end
      Q_FIN: begin
        c_d     = anc_node;
        state_d = Q_DIST;
      end
      Q_DIST: begin
        vld_d   = 1'b1;
        anc_d   = FIELD_W'(c_q);
        dist_d  = DIST_W'(da_q) + DIST_W'(db_q) - (DIST_W'(dep_a_i) << 1);
        state_d = Q_IDLE;
      end
      default: state_d = Q_IDLE;
    endcase
  end

  // memory read addresses for each step
  always_comb begin
    anc_req_o.addr_a = anc_addr(lv_q, low_q);
    anc_req_o.addr_b = anc_addr(lv_q, high_q);
    anc_req_o.we     = 1'b0;
    anc_req_o.waddr  = '0;
    anc_req_o.wdata  = '0;
    dep_req_o.addr_a = a_q;
    dep_req_o.addr_b = b_q;
    case (state_q)
      Q_ANC:   dep_req_o.addr_a = anc_node;
      Q_CHECK: begin
        dep_req_o.addr_a = low_q;
        anc_req_o.addr_a = anc_addr(LVL_W'(LOG_LEVELS - 1), low_q);
        anc_req_o.addr_b = anc_addr(LVL_W'(LOG_LEVELS - 1), high_q);
      end
      Q_CMP: begin
        if (lv_q == '0) begin
          anc_req_o.addr_a = anc_addr('0, nlow);
        end else begin
          anc_req_o.addr_a = anc_addr(lv_next, nlow);
          anc_req_o.addr_b = anc_addr(lv_next, nhigh);
        end
      end
      Q_FIN:   dep_req_o.addr_a = anc_node;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      vld_q   <= 1'b0;
      fresh_q <= 1'b0;
      lv_q    <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      fresh_q <= fresh_d;
      lv_q    <= lv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    low_q   <= low_d;
    high_q  <= high_d;
    c_q     <= c_d;
    da_q    <= da_d;
    db_q    <= db_d;
    dlow_q  <= dlow_d;
    dhigh_q <= dhigh_d;
    anc_q   <= anc_d;
    dist_q  <= dist_d;
  end

endmodule
`default_nettype wire

>>> hdl/tree_lca_distance_top.sv
// top level of the tree lowest-common-ancestor and path-length block
//
// Usage: an item is taken when start_i is high and busy_o is low. command_i
// selects load (write parent and depth of node_index_i), build (fill the
// power-of-two ancestor levels for nodes 0 to node_count) or query (lowest
// common ancestor and edge count between node_index_i and other_node_i).
// A load completes at the edge that takes it; busy_o stays low.
// A build runs one node per cycle for each level above the first, and
// drains the read-read-write pipe at the end of each level.
// A query runs a depth fetch, a depth-equalizing pass over the levels (each
// lift reads the ancestor, then its depth), a joint pass over the levels on
// the two ancestor read ports when the nodes still differ, and a final depth
// read. Its result sits on common_ancestor_o and path_length_o for one cycle
// with result_valid_o, which the receiver cannot hold off.
// node_count is written through cfg_we_i and cfg_wdata_i; the user must write
// it only while idle, as the block itself does not enforce it.
// Reset clears the control state and sets node_count to 1; the tables hold
// nothing defined until they are loaded and built.
`default_nettype none
module tree_lca_distance_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  node_index_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  other_node_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  depth_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [lcad_pkg::FIELD_W-1:0]  cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [lcad_pkg::FIELD_W-1:0]       common_ancestor_o,
  output logic [lcad_pkg::DIST_W-1:0]        path_length_o
);
  import lcad_pkg::*;

  logic [FIELD_W-1:0] node_count_q;
  logic               accept, load_wr, build_go, query_go;
  logic [NODE_W-1:0]  last_node, node_in, other_in;
  logic               build_busy, query_busy;
  anc_req_t           build_req, query_req;
  dep_req_t           dep_req;
  logic               anc_we;
  logic [ANC_AW-1:0]  anc_waddr, anc_raddr_a, anc_raddr_b;
  logic [FIELD_W-1:0] anc_wdata, anc_rd_a, anc_rd_b, dep_rd_a, dep_rd_b;

  // command decode
  assign accept = start_i && !busy_o;
  always_comb begin
    load_wr  = 1'b0;
    build_go = 1'b0;
    query_go = 1'b0;
    case (cmd_e'(command_i))
      CMD_LOAD:  load_wr  = accept;
      CMD_BUILD: build_go = accept;
      CMD_QUERY: query_go = accept;
      default: ;
    endcase
  end

  assign node_in  = NODE_W'(node_index_i);
  assign other_in = NODE_W'(other_node_i);
  assign busy_o   = build_busy || query_busy;

  // configuration register and the highest node a build covers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= FIELD_W'(1);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end
  assign last_node = (32'(node_count_q) > (MAX_NODES - 1)) ? NODE_W'(MAX_NODES - 1)
                                                           : NODE_W'(node_count_q);

  lcad_build u_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (build_go),
    .last_i    (last_node),
    .rdata_a_i (anc_rd_a),
    .rdata_b_i (anc_rd_b),
    .req_o     (build_req),
    .busy_o    (build_busy)
  );

  lcad_query u_query (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .go_i           (query_go),
    .node_i         (node_in),
    .other_i        (other_in),
    .anc_a_i        (anc_rd_a),
    .anc_b_i        (anc_rd_b),
    .dep_a_i        (dep_rd_a),
    .dep_b_i        (dep_rd_b),
    .anc_req_o      (query_req),
    .dep_req_o      (dep_req),
    .busy_o         (query_busy),
    .res_valid_o    (result_valid_o),
    .res_ancestor_o (common_ancestor_o),
    .res_dist_o     (path_length_o)
  );

  // ancestor memory port sharing: load writes level 0, build owns it while busy
  assign anc_we      = load_wr || build_req.we;
  assign anc_waddr   = load_wr ? anc_addr('0, node_in) : build_req.waddr;
  assign anc_wdata   = load_wr ? other_node_i : build_req.wdata;
  assign anc_raddr_a = build_busy ? build_req.addr_a : query_req.addr_a;
  assign anc_raddr_b = build_busy ? build_req.addr_b : query_req.addr_b;

  lcad_ram #(
    .WIDTH  (FIELD_W),
    .DEPTH  (ANC_DEPTH),
    .ADDR_W (ANC_AW)
  ) u_anc_ram (
    .clk_i     (clk_i),
    .we_i      (anc_we),
    .waddr_i   (anc_waddr),
    .wdata_i   (anc_wdata),
    .raddr_a_i (anc_raddr_a),
    .raddr_b_i (anc_raddr_b),
    .rdata_a_o (anc_rd_a),
    .rdata_b_o (anc_rd_b)
  );

  lcad_ram #(
    .WIDTH  (FIELD_W),
    .DEPTH  (MAX_NODES),
    .ADDR_W (NODE_W)
  ) u_dep_ram (
    .clk_i     (clk_i),
    .we_i      (load_wr),
    .waddr_i   (node_in),
    .wdata_i   (depth_value_i),
    .raddr_a_i (dep_req.addr_a),
    .raddr_b_i (dep_req.addr_b),
    .rdata_a_o (dep_rd_a),
    .rdata_b_o (dep_rd_b)
  );

endmodule
`default_nettype wire

>>> hdl/lcad_checker.sv
// port-level checker for the tree lca block, bound to the top level
`default_nettype none
`include "tree_lca_distance_top_assert.svh"
module lcad_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic [1:0]                    command_i,
  input wire logic                          result_valid_o
);
  import lcad_pkg::*;

  logic take_load, take_build, take_query;

  assign take_load  = start_i && !busy_o && (command_i == CMD_LOAD);
  assign take_build = start_i && !busy_o && (command_i == CMD_BUILD);
  assign take_query = start_i && !busy_o && (command_i == CMD_QUERY);

  // a query or a build holds the block busy in the next cycle
  `LCAD_ASSERT_NEXT(a_query_busy, take_query, busy_o, "query item did not raise busy")
  `LCAD_ASSERT_NEXT(a_build_busy, take_build, busy_o, "build item did not raise busy")
  // a load finishes at the edge that takes it
  `LCAD_ASSERT_NEXT(a_load_done, take_load, !busy_o, "load item left the block busy")
  // a result follows a busy cycle and never repeats in the next cycle
  `LCAD_ASSERT_SAME(a_res_after_busy, result_valid_o, $past(busy_o), "result without query")
  `LCAD_ASSERT_NEXT(a_res_single, result_valid_o, !result_valid_o, "result strobe repeated")

endmodule

bind tree_lca_distance_top lcad_checker u_lcad_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .command_i      (command_i),
  .result_valid_o (result_valid_o)
);
`default_nettype wire
